// ===== sv/ccs_pkg.sv =====
// ccs_pkg: shared types and constants for the c comment stripper
// scan mode encoding, character codes, result record and scanner outputs
// no dependencies
package ccs_pkg;

  // character codes the scanner reacts to
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // result queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = FIFO_AW + 1;

  // scanner state
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_HELD   = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_BSTAR  = 3'd4
  } scan_mode_t;

  // one result item
  typedef struct packed {
    logic       string_end;
    logic       run_last;
    logic       has_char;
    logic [7:0] out_char;
  } result_t;

  // everything one input byte produces
  typedef struct packed {
    logic [1:0] count;
    result_t    r1;
    result_t    r0;
  } scan_res_t;

endpackage

// ===== sv/ccs_scan.sv =====
// ccs_scan: comment scanner state machine, one byte per step
// produces up to two results per byte from the current scan mode
// depends on ccs_pkg
module ccs_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        in_char,
  input  logic              string_last,
  output ccs_pkg::scan_res_t res
);

  ccs_pkg::scan_mode_t mode_r;
  ccs_pkg::scan_mode_t mode_nxt;
  ccs_pkg::scan_mode_t mode_body;

  logic is_slash;
  logic is_star;
  logic is_nl;

  assign is_slash = (in_char == ccs_pkg::CH_SLASH);
  assign is_star  = (in_char == ccs_pkg::CH_STAR);
  assign is_nl    = (in_char == ccs_pkg::CH_NL);

  // next state: mode transition, then string end forces normal
  always_comb begin
    case (mode_r)
      ccs_pkg::MODE_HELD: begin
        if (is_slash) mode_body = ccs_pkg::MODE_LINE;
        else if (is_star) mode_body = ccs_pkg::MODE_BSTAR;
        else mode_body = ccs_pkg::MODE_NORMAL;
      end
      ccs_pkg::MODE_LINE: begin
        mode_body = is_nl ? ccs_pkg::MODE_NORMAL : ccs_pkg::MODE_LINE;
      end
      ccs_pkg::MODE_BLOCK: begin
        mode_body = is_star ? ccs_pkg::MODE_BSTAR : ccs_pkg::MODE_BLOCK;
      end
      ccs_pkg::MODE_BSTAR: begin
        if (is_slash) mode_body = ccs_pkg::MODE_NORMAL;
        else if (is_star) mode_body = ccs_pkg::MODE_BSTAR;
        else mode_body = ccs_pkg::MODE_BLOCK;
      end
      default: begin
        mode_body = is_slash ? ccs_pkg::MODE_HELD : ccs_pkg::MODE_NORMAL;
      end
    endcase
    mode_nxt = string_last ? ccs_pkg::MODE_NORMAL : mode_body;
  end

  // outputs: results caused by this byte
  always_comb begin
    res = '0;
    case (mode_r)
      ccs_pkg::MODE_HELD: begin
        if (!is_slash && !is_star) begin
          res.r0    = '{string_end: 1'b0, run_last: 1'b0, has_char: 1'b1,
                        out_char: ccs_pkg::CH_SLASH};
          res.r1    = '{string_end: string_last, run_last: 1'b1, has_char: 1'b1,
                        out_char: in_char};
          res.count = 2'd2;
        end
      end
      ccs_pkg::MODE_LINE,
      ccs_pkg::MODE_BLOCK,
      ccs_pkg::MODE_BSTAR: begin
        res.count = 2'd0;
      end
      default: begin
        if (!is_slash) begin
          res.r0    = '{string_end: string_last, run_last: 1'b1, has_char: 1'b1,
                        out_char: in_char};
          res.count = 2'd1;
        end
      end
    endcase
    // string end with nothing emitted: release held slash or bare marker
    if (string_last && res.count == 2'd0) begin
      if (mode_body == ccs_pkg::MODE_HELD) begin
        res.r0 = '{string_end: 1'b1, run_last: 1'b1, has_char: 1'b1,
                   out_char: ccs_pkg::CH_SLASH};
      end else begin
        res.r0 = '{string_end: 1'b1, run_last: 1'b1, has_char: 1'b0,
                   out_char: 8'h00};
      end
      res.count = 2'd1;
    end
  end

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ccs_pkg::MODE_NORMAL;
    end else if (step) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

// ===== sv/ccs_out_fifo.sv =====
// ccs_out_fifo: four-entry result queue, takes up to two results a cycle
// head entry drives the output channel directly
// depends on ccs_pkg
module ccs_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ccs_pkg::scan_res_t  res,
  input  logic                pop,
  output logic                room2,
  output logic                not_empty,
  output ccs_pkg::result_t    head
);

  ccs_pkg::result_t                   mem_r [ccs_pkg::FIFO_DEPTH];
  logic [ccs_pkg::FIFO_AW-1:0]        wr_ptr_r;
  logic [ccs_pkg::FIFO_AW-1:0]        wr_ptr_nxt;
  logic [ccs_pkg::FIFO_AW-1:0]        wr_ptr_p1;
  logic [ccs_pkg::FIFO_AW-1:0]        rd_ptr_r;
  logic [ccs_pkg::FIFO_CW-1:0]        count_r;
  logic [ccs_pkg::FIFO_CW-1:0]        count_nxt;
  logic [1:0]                         n_push;

  assign n_push     = push ? res.count : 2'd0;
  assign wr_ptr_p1  = ccs_pkg::FIFO_AW'(wr_ptr_r + 1'b1);
  assign wr_ptr_nxt = ccs_pkg::FIFO_AW'(wr_ptr_r + n_push);
  assign count_nxt  = ccs_pkg::FIFO_CW'(count_r + n_push - (pop ? 1'b1 : 1'b0));

  // room for a full two-result burst
  assign room2     = (count_r <= ccs_pkg::FIFO_CW'(ccs_pkg::FIFO_DEPTH - 2));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  // entry writes
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_ptr_r] <= res.r0;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_ptr_p1] <= res.r1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      if (pop) begin
        rd_ptr_r <= ccs_pkg::FIFO_AW'(rd_ptr_r + 1'b1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== sv/c_comment_stripper.sv =====
// c_comment_stripper: removes c style comments from a byte stream
// top level: input register, scanner and result queue
// depends on ccs_pkg, ccs_scan, ccs_out_fifo
//
//   channel | ports        | tdata        | tuser                     | tlast
//   --------+--------------+--------------+---------------------------+-----------
//   input   | in_t*        | in_char      | -                         | string_last
//   result  | out_t*       | out_char     | has_char, run_last        | string_end
//
// one byte per cycle is taken while each byte gives at most one result and the
// result side is ready; a byte that gives two results (held slash released
// before an ordinary byte) pushes both into the result queue together.
// the byte is held in the input register; its results are written into the
// result queue, and the head of the queue drives the result port.
// a byte waits in the input register, and the input stalls behind it, while the
// four-entry result queue has fewer than two free entries.
// synchronous reset clears the scan mode, the input register and the queue.
module c_comment_stripper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic [1:0] out_tuser,  // [0] has_char, [1] run_last
  output logic       out_tlast
);

  logic               in_valid_r;
  logic               in_valid_nxt;
  logic [7:0]         in_char_r;
  logic               in_last_r;
  logic               in_xfer;
  logic               advance;
  logic               room2;
  logic               not_empty;
  logic               pop;
  ccs_pkg::scan_res_t res;
  ccs_pkg::result_t   head;

  // input register hands its byte to the scanner when the queue has room
  assign advance      = in_valid_r && room2;
  assign in_tready    = !in_valid_r || advance;
  assign in_xfer      = in_tvalid && in_tready;
  assign in_valid_nxt = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // scanner
  ccs_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .in_char     (in_char_r),
    .string_last (in_last_r),
    .res         (res)
  );

  // result queue
  assign pop = out_tvalid && out_tready;

  ccs_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (advance),
    .res       (res),
    .pop       (pop),
    .room2     (room2),
    .not_empty (not_empty),
    .head      (head)
  );

  // result channel
  assign out_tvalid = not_empty;
  assign out_tdata  = head.out_char;
  assign out_tuser  = {head.run_last, head.has_char};
  assign out_tlast  = head.string_end;

endmodule

// ===== sv/ccs_checker.sv =====
// ccs_checker: port-level checks for c_comment_stripper
// sees only the top level result ports; bound to the top level below
// no package dependencies
module ccs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result payload changed while stalled");

  // string end is always the last result of its byte
  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[1])
    else $error("string end without run_last");

  // a bare marker only closes a string and carries a zero byte
  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |->
      out_tlast && out_tuser[1] && (out_tdata == 8'h00))
    else $error("malformed bare end marker");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

endmodule

bind c_comment_stripper ccs_checker u_ccs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
